// ===== src/ase_pkg.sv =====
package ase_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int WIDTH_DEF = 32;

    localparam int COUNT_W = 9;
    localparam int MODE_W  = 2;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 8;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic REG_ELEM_COUNT  = 1'b0;
    localparam logic REG_SEARCH_MODE = 1'b1;

    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BIDIR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BINARY = 2'd2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LIN,
        S_BID_LO,
        S_BID_HI,
        S_BIN_MID,
        S_BIN_RM,
        S_BIN_RL,
        S_BIN_RH,
        S_BIN_CHK,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RD_LO,
        RD_HI,
        RD_MID
    } t_rd_sel;

    typedef struct packed {
        logic    start;
        logic    write;
        t_rd_sel rd_sel;
        logic    lin_adv;
        logic    bid_adv;
        logic    mid_calc;
        logic    mid_cap;
        logic    bin_upd;
    } t_dp_cmd;

    typedef struct packed {
        logic span_ok;
        logic eq;
        logic mid_eq;
    } t_dp_sts;

endpackage

// ===== src/ase_cfg.sv =====
module ase_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [ase_pkg::ADDR_W-1:0]        i_paddr,
    input  logic [ase_pkg::DATA_W-1:0]        i_pwdata,
    output logic [ase_pkg::DATA_W-1:0]        o_prdata,
    output logic                              o_pready,
    output logic [ase_pkg::COUNT_W-1:0]       o_count,
    output logic [ase_pkg::MODE_W-1:0]        o_mode
);

    logic [ase_pkg::COUNT_W-1:0] r_count;
    logic [ase_pkg::MODE_W-1:0]  r_mode;
    logic                        wr_en;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_mode  <= ase_pkg::MODE_BINARY;
        end else if (wr_en) begin
            case (i_paddr[2])
                ase_pkg::REG_ELEM_COUNT: begin
                    r_count <= i_pwdata[ase_pkg::COUNT_W-1:0];
                end
                ase_pkg::REG_SEARCH_MODE: begin
                    r_mode <= i_pwdata[ase_pkg::MODE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (i_paddr[2])
            ase_pkg::REG_ELEM_COUNT:  o_prdata = ase_pkg::DATA_W'(r_count);
            ase_pkg::REG_SEARCH_MODE: o_prdata = ase_pkg::DATA_W'(r_mode);
            default:                  o_prdata = '0;
        endcase
    end

    assign o_count = r_count;
    assign o_mode  = r_mode;

endmodule

// ===== src/ase_dp.sv =====
module ase_dp #(
    parameter int DEPTH = ase_pkg::DEPTH_DEF,
    parameter int WIDTH = ase_pkg::WIDTH_DEF
) (
    input  logic                                i_clk,
    input  ase_pkg::t_dp_cmd                    i_cmd,
    input  logic [ase_pkg::INDEX_W-1:0]         i_index,
    input  logic signed [ase_pkg::VALUE_W-1:0]  i_value,
    input  logic [ase_pkg::COUNT_W-1:0]         i_count,
    output ase_pkg::t_dp_sts                    o_sts
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = $clog2(DEPTH + 1) + 1;
    localparam logic signed [PW-1:0] ONE = PW'(1);

    logic [WIDTH-1:0]       r_mem [DEPTH];
    logic [WIDTH-1:0]       r_rdata;
    logic [WIDTH-1:0]       r_key;
    logic signed [PW-1:0]   r_lo;
    logic signed [PW-1:0]   r_hi;
    logic signed [PW-1:0]   r_mid;
    logic                   r_mid_eq;
    logic                   r_mid_lt;

    logic [WIDTH-1:0]       val_ext;
    logic signed [PW-1:0]   n_lim;
    logic [AW-1:0]          rd_addr;
    logic                   eq;
    logic                   lt;

    // Sign-extend or truncate the 32-bit field to the store width.
    assign val_ext = WIDTH'(i_value);

    always_comb begin
        if ({{(32 - ase_pkg::COUNT_W){1'b0}}, i_count} > 32'(DEPTH)) begin
            n_lim = PW'(DEPTH);
        end else begin
            n_lim = PW'(i_count);
        end
    end

    always_comb begin
        case (i_cmd.rd_sel)
            ase_pkg::RD_LO:  rd_addr = r_lo[AW-1:0];
            ase_pkg::RD_HI:  rd_addr = r_hi[AW-1:0];
            ase_pkg::RD_MID: rd_addr = r_mid[AW-1:0];
            default:         rd_addr = r_lo[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && (32'(i_index) < 32'(DEPTH))) begin
            r_mem[AW'(i_index)] <= val_ext;
        end
        r_rdata <= r_mem[rd_addr];
    end

    assign eq = (r_rdata == r_key);
    assign lt = ($signed(r_rdata) < $signed(r_key));

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key <= val_ext;
            r_lo  <= '0;
            r_hi  <= n_lim - ONE;
        end else if (i_cmd.lin_adv) begin
            r_lo <= r_lo + ONE;
        end else if (i_cmd.bid_adv) begin
            r_lo <= r_lo + ONE;
            r_hi <= r_hi - ONE;
        end else if (i_cmd.bin_upd) begin
            if (r_mid_lt) begin
                r_lo <= r_mid + ONE;
            end else begin
                r_hi <= r_mid - ONE;
            end
        end
        if (i_cmd.mid_calc) begin
            r_mid <= r_lo + ((r_hi - r_lo) >>> 1);
        end
        if (i_cmd.mid_cap) begin
            r_mid_eq <= eq;
            r_mid_lt <= lt;
        end
    end

    assign o_sts.span_ok = (r_lo <= r_hi);
    assign o_sts.eq      = eq;
    assign o_sts.mid_eq  = r_mid_eq;

endmodule

// ===== src/ase_ctrl.sv =====
module ase_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_op,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_found,
    input  logic [ase_pkg::MODE_W-1:0]   i_mode,
    output ase_pkg::t_dp_cmd             o_cmd,
    input  ase_pkg::t_dp_sts             i_sts
);

    ase_pkg::t_state r_state, n_state;
    logic            r_pend, n_pend;
    logic            r_res, n_res;
    logic            r_out_valid, n_out_valid;
    logic            r_found, n_found;
    logic            out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ase_pkg::S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res   <= n_res;
        r_found <= n_found;
    end

    always_comb begin
        n_state     = r_state;
        n_pend      = 1'b0;
        n_res       = r_res;
        n_found     = r_found;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.rd_sel = ase_pkg::RD_LO;

        case (r_state)
            ase_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == ase_pkg::OP_WRITE) begin
                        o_cmd.write = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        case (i_mode)
                            ase_pkg::MODE_LINEAR: n_state = ase_pkg::S_LIN;
                            ase_pkg::MODE_BIDIR:  n_state = ase_pkg::S_BID_LO;
                            default:              n_state = ase_pkg::S_BIN_MID;
                        endcase
                    end
                end
            end
            ase_pkg::S_LIN: begin
                if (r_pend && i_sts.eq) begin
                    n_res   = 1'b1;
                    n_state = ase_pkg::S_DONE;
                end else if (i_sts.span_ok) begin
                    o_cmd.rd_sel  = ase_pkg::RD_LO;
                    o_cmd.lin_adv = 1'b1;
                    n_pend        = 1'b1;
                end else if (!r_pend) begin
                    n_res   = 1'b0;
                    n_state = ase_pkg::S_DONE;
                end
            end
            ase_pkg::S_BID_LO: begin
                if (r_pend && i_sts.eq) begin
                    n_res   = 1'b1;
                    n_state = ase_pkg::S_DONE;
                end else if (i_sts.span_ok) begin
                    o_cmd.rd_sel = ase_pkg::RD_LO;
                    n_pend       = 1'b1;
                    n_state      = ase_pkg::S_BID_HI;
                end else if (!r_pend) begin
                    n_res   = 1'b0;
                    n_state = ase_pkg::S_DONE;
                end
            end
            ase_pkg::S_BID_HI: begin
                if (r_pend && i_sts.eq) begin
                    n_res   = 1'b1;
                    n_state = ase_pkg::S_DONE;
                end else begin
                    o_cmd.rd_sel  = ase_pkg::RD_HI;
                    o_cmd.bid_adv = 1'b1;
                    n_pend        = 1'b1;
                    n_state       = ase_pkg::S_BID_LO;
                end
            end
            ase_pkg::S_BIN_MID: begin
                o_cmd.mid_calc = 1'b1;
                if (i_sts.span_ok) begin
                    n_state = ase_pkg::S_BIN_RM;
                end else begin
                    n_res   = 1'b0;
                    n_state = ase_pkg::S_DONE;
                end
            end
            ase_pkg::S_BIN_RM: begin
                o_cmd.rd_sel = ase_pkg::RD_MID;
                n_state      = ase_pkg::S_BIN_RL;
            end
            ase_pkg::S_BIN_RL: begin
                o_cmd.rd_sel  = ase_pkg::RD_LO;
                o_cmd.mid_cap = 1'b1;
                n_state       = ase_pkg::S_BIN_RH;
            end
            ase_pkg::S_BIN_RH: begin
                o_cmd.rd_sel = ase_pkg::RD_HI;
                if (i_sts.eq || i_sts.mid_eq) begin
                    n_res   = 1'b1;
                    n_state = ase_pkg::S_DONE;
                end else begin
                    n_state = ase_pkg::S_BIN_CHK;
                end
            end
            ase_pkg::S_BIN_CHK: begin
                if (i_sts.eq) begin
                    n_res   = 1'b1;
                    n_state = ase_pkg::S_DONE;
                end else begin
                    o_cmd.bin_upd = 1'b1;
                    n_state       = ase_pkg::S_BIN_MID;
                end
            end
            ase_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_found     = r_res;
                    n_state     = ase_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ase_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ase_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;

    a_search_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ase_pkg::S_IDLE && i_in_valid && i_op == ase_pkg::OP_SEARCH)
        |=> (r_state != ase_pkg::S_IDLE))
        else $error("search transfer did not start a scan");

    a_write_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ase_pkg::S_IDLE && i_in_valid && i_op == ase_pkg::OP_WRITE)
        |=> (r_state == ase_pkg::S_IDLE && !o_out_valid || r_state == ase_pkg::S_IDLE))
        else $error("write transfer left idle");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ase_pkg::S_DONE))
        else $error("result loaded outside done state");

    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == ase_pkg::S_LIN || r_state == ase_pkg::S_BID_LO ||
                    r_state == ase_pkg::S_BID_HI))
        else $error("read pending outside a scan state");

endmodule

// ===== src/array_search_engine_top.sv =====
// Write transfer: store updated at the accepting edge, no result.
// Search, linear or bidirectional: scans up to n = min(element_count, DEPTH) elements,
// one store read per cycle through the single read port, compares pipelined behind it.
// Search, binary: at most floor(log2(n)) + 1 probes, each reading mid, low, then high.
// One item in work at a time; a new transfer is taken while a result waits in the output reg.
// Reset clears control and config (element_count 0, search_mode 2); the store is not cleared.
module array_search_engine_top #(
    parameter int DEPTH = ase_pkg::DEPTH_DEF,
    parameter int WIDTH = ase_pkg::WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ase_pkg::ADDR_W-1:0]          paddr,
    input  logic [ase_pkg::DATA_W-1:0]          pwdata,
    output logic [ase_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,

    // item channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_op,
    input  logic [ase_pkg::INDEX_W-1:0]         i_index,
    input  logic signed [ase_pkg::VALUE_W-1:0]  i_value,

    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_found
);

    logic [ase_pkg::COUNT_W-1:0] cfg_count;
    logic [ase_pkg::MODE_W-1:0]  cfg_mode;
    ase_pkg::t_dp_cmd            dp_cmd;
    ase_pkg::t_dp_sts            dp_sts;

    // Register block: element_count at byte 0, search_mode at byte 4.
    ase_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_count   (cfg_count),
        .o_mode    (cfg_mode)
    );

    // Sequencer: picks the probe order per mode, owns the handshakes and the
    // output register.
    ase_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_found     (o_found),
        .i_mode      (cfg_mode),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    // Store, key, low/high/mid pointers and the comparators.
    ase_dp #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_cmd   (dp_cmd),
        .i_index (i_index),
        .i_value (i_value),
        .i_count (cfg_count),
        .o_sts   (dp_sts)
    );

endmodule
